[hw/rtl/stps_pkg.sv]
`timescale 1ns / 1ps

package stps_pkg;

	// Register indexes (byte address = 4 * index)
	localparam logic [2:0] REG_AMPLITUDE        = 3'd0;
	localparam logic [2:0] REG_GAIN_Q8          = 3'd1;
	localparam logic [2:0] REG_CORRECTION_LIMIT = 3'd2;
	localparam logic [2:0] REG_LOWEST_TICK      = 3'd3;
	localparam logic [2:0] REG_HIGHEST_TICK     = 3'd4;
	localparam logic [2:0] REG_PHASE_RATE       = 3'd5;
	localparam logic [2:0] REG_AXIS_PHASE_STEP  = 3'd6;

	// Register reset values
	localparam logic [10:0] AMPLITUDE_RST        = 11'd20;
	localparam logic [11:0] GAIN_Q8_RST          = 12'd77;
	localparam logic [11:0] CORRECTION_LIMIT_RST = 12'd300;
	localparam logic [11:0] LOWEST_TICK_RST      = 12'd0;
	localparam logic [11:0] HIGHEST_TICK_RST     = 12'd4095;
	localparam logic [29:0] PHASE_RATE_RST       = 30'd2147;
	localparam logic [15:0] AXIS_PHASE_STEP_RST  = 16'd1565;

	// Sine table generation constants (Q30)
	localparam longint unsigned PI_Q30  = 64'd3373259426;
	localparam longint unsigned ONE_Q30 = 64'd1073741824;

	typedef struct packed {
		logic [10:0] amplitude;
		logic [11:0] gain_q8;
		logic [11:0] correction_limit;
		logic [11:0] lowest_tick;
		logic [11:0] highest_tick;
		logic [29:0] phase_rate;
		logic [15:0] axis_phase_step;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_T_MUL,
		ST_T_ADD,
		ST_P_MUL,
		ST_P_ROM,
		ST_A_MUL,
		ST_A_RND,
		ST_REF,
		ST_DIFF,
		ST_E_MUL,
		ST_E_RND,
		ST_LIMIT,
		ST_CMD,
		ST_WRITE
	} state_t;

	typedef enum logic [1:0] {
		MUL_TIME,
		MUL_PHASE,
		MUL_AMP,
		MUL_ERR
	} mul_sel_t;

	typedef struct packed {
		logic     capture;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     acc_add;
		logic     rom_rd;
		logic     ref_rnd;
		logic     ref_en;
		logic     diff_en;
		logic     corr_rnd;
		logic     lim_en;
		logic     cmd_en;
		logic     load_out;
	} cmd_t;

	typedef struct packed {
		logic is_time;
		logic in_range;
		logic pos_valid;
		logic out_free;
	} sts_t;

	// Quarter-wave sine, angle r / 2^bits turns, 0 <= r <= 2^(bits-2), Q15 result
	function automatic logic [15:0] quarter_sine(int unsigned bits, longint unsigned r);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		longint unsigned d;
		longint unsigned s;
		longint unsigned q;
		x  = (PI_Q30 * r) >> (bits - 1);
		x2 = (x * x) >> 30;
		t  = ONE_Q30;
		for (int i = 0; i < 5; i++) begin
			d = (x2 * t) >> 30;
			case (i)
				0: d = d / 110;
				1: d = d / 72;
				2: d = d / 42;
				3: d = d / 20;
				default: d = d / 6;
			endcase
			t = (d >= ONE_Q30) ? 64'd0 : ONE_Q30 - d;
		end
		s = (x * t) >> 30;
		q = (s + 64'd16384) >> 15;
		if (q > 64'd32767) begin
			q = 64'd32767;
		end
		return q[15:0];
	endfunction

	// Full-wave table entry k of 2^bits, built from quadrant symmetry
	function automatic logic signed [15:0] sine_entry(int unsigned bits, int unsigned k);
		int unsigned quarter;
		int unsigned qd;
		int unsigned r;
		logic signed [15:0] v;
		quarter = 1 << (bits - 2);
		qd      = k >> (bits - 2);
		r       = k & (quarter - 1);
		if ((qd & 1) != 0) begin
			v = $signed(quarter_sine(bits, longint'(quarter - r)));
		end else begin
			v = $signed(quarter_sine(bits, longint'(r)));
		end
		return ((qd & 2) != 0) ? -v : v;
	endfunction

endpackage

[hw/rtl/stps_ctrl.sv]
`timescale 1ns / 1ps

module stps_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_stall,
	input  stps_pkg::sts_t  sts,
	output stps_pkg::cmd_t  cmd
);
	import stps_pkg::*;

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					state_next = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (sts.is_time) begin
					state_next = ST_T_MUL;
				end else if (sts.in_range) begin
					state_next = ST_P_MUL;
				end else begin
					state_next = ST_IDLE;
				end
			end
			ST_T_MUL: state_next = ST_T_ADD;
			ST_T_ADD: state_next = ST_IDLE;
			ST_P_MUL: state_next = ST_P_ROM;
			ST_P_ROM: state_next = ST_A_MUL;
			ST_A_MUL: state_next = ST_A_RND;
			ST_A_RND: state_next = ST_REF;
			ST_REF: begin
				state_next = sts.pos_valid ? ST_DIFF : ST_WRITE;
			end
			ST_DIFF:  state_next = ST_E_MUL;
			ST_E_MUL: state_next = ST_E_RND;
			ST_E_RND: state_next = ST_LIMIT;
			ST_LIMIT: state_next = ST_CMD;
			ST_CMD:   state_next = ST_WRITE;
			ST_WRITE: begin
				if (sts.out_free) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		cmd.mul_sel = MUL_TIME;
		item_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: cmd.capture = item_valid;
			ST_T_MUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_TIME;
			end
			ST_T_ADD: cmd.acc_add = 1'b1;
			ST_P_MUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_PHASE;
			end
			ST_P_ROM: cmd.rom_rd = 1'b1;
			ST_A_MUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_AMP;
			end
			ST_A_RND: cmd.ref_rnd = 1'b1;
			ST_REF:   cmd.ref_en = 1'b1;
			ST_DIFF:  cmd.diff_en = 1'b1;
			ST_E_MUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_ERR;
			end
			ST_E_RND: cmd.corr_rnd = 1'b1;
			ST_LIMIT: cmd.lim_en = 1'b1;
			ST_CMD:   cmd.cmd_en = 1'b1;
			ST_WRITE: cmd.load_out = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

[hw/rtl/stps_dp.sv]
`timescale 1ns / 1ps

module stps_dp #(
	parameter int MOTOR_COUNT     = 32,
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  stps_pkg::cfg_t     cfg,
	input  stps_pkg::cmd_t     cmd,
	output stps_pkg::sts_t     sts,
	input  logic               action,
	input  logic [15:0]        elapsed_us,
	input  logic [4:0]         motor_index,
	input  logic [11:0]        center_tick,
	input  logic signed [31:0] present_position,
	input  logic               position_valid,
	input  logic               result_stall,
	output logic               result_valid,
	output logic [11:0]        reference,
	output logic [11:0]        command,
	output logic               send
);
	import stps_pkg::*;

	localparam int SINE_SIZE = 1 << SINE_TABLE_BITS;
	localparam logic [8:0] MOTOR_LIMIT = 9'(MOTOR_COUNT);

	typedef logic signed [15:0] sine_rom_t [SINE_SIZE];

	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		for (int k = 0; k < SINE_SIZE; k++) begin
			rom[k] = sine_entry(SINE_TABLE_BITS, k);
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

	function automatic logic [11:0] clamp_tick(logic signed [13:0] v, logic [11:0] lo,
			logic [11:0] hi);
		logic signed [13:0] lo_s;
		logic signed [13:0] hi_s;
		lo_s = $signed({2'b00, lo});
		hi_s = $signed({2'b00, hi});
		if (v < lo_s) begin
			return lo;
		end else if (v > hi_s) begin
			return hi;
		end else begin
			return v[11:0];
		end
	endfunction

	// captured transaction
	logic                 action_q;
	logic [15:0]          elapsed_q;
	logic [4:0]           idx_q;
	logic [11:0]          center_q;
	logic signed [31:0]   pos_q;
	logic                 pvalid_q;

	logic [31:0]          acc_q;
	logic signed [49:0]   prod_q;
	logic signed [15:0]   rom_q;
	logic signed [11:0]   off_q;
	logic [11:0]          ref_q;
	logic signed [32:0]   diff_q;
	logic signed [37:0]   u_q;
	logic signed [12:0]   corr_q;
	logic [11:0]          cmdv_q;

	logic                 result_valid_q;
	logic [11:0]          reference_q;
	logic [11:0]          command_q;
	logic                 send_q;

	logic signed [32:0]   mul_a;
	logic signed [16:0]   mul_b;
	logic [31:0]          phase_sum;
	logic [SINE_TABLE_BITS-1:0] rom_addr;
	logic signed [49:0]   ref_rnd_sum;
	logic signed [49:0]   corr_rnd_sum;
	logic signed [13:0]   ref_raw;
	logic signed [13:0]   cmd_raw;
	logic signed [37:0]   lim_pos;
	logic signed [37:0]   lim_neg;
	logic signed [12:0]   corr_next;

	always_comb begin
		case (cmd.mul_sel)
			MUL_TIME: begin
				mul_a = $signed({3'd0, cfg.phase_rate});
				mul_b = $signed({1'b0, elapsed_q});
			end
			MUL_PHASE: begin
				mul_a = $signed({28'd0, idx_q});
				mul_b = $signed({1'b0, cfg.axis_phase_step});
			end
			MUL_AMP: begin
				mul_a = $signed({22'd0, cfg.amplitude});
				mul_b = $signed({rom_q[15], rom_q});
			end
			MUL_ERR: begin
				mul_a = diff_q;
				mul_b = $signed({5'd0, cfg.gain_q8});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// motor offset sits in the upper half of the phase; the full sum carries into the index
	assign phase_sum = acc_q + {prod_q[15:0], 16'h0000};
	assign rom_addr  = phase_sum[31 -: SINE_TABLE_BITS];

	// round half away from zero: negative values take one less before the shift
	assign ref_rnd_sum  = prod_q + (prod_q[49] ? 50'sd16383 : 50'sd16384);
	assign corr_rnd_sum = prod_q + (prod_q[49] ? 50'sd127 : 50'sd128);

	assign ref_raw = $signed({2'b00, center_q}) + $signed({{2{off_q[11]}}, off_q});
	assign cmd_raw = $signed({2'b00, ref_q}) + $signed({corr_q[12], corr_q});

	assign lim_pos = $signed({26'd0, cfg.correction_limit});
	assign lim_neg = -lim_pos;

	always_comb begin
		if (u_q > lim_pos) begin
			corr_next = $signed({1'b0, cfg.correction_limit});
		end else if (u_q < lim_neg) begin
			corr_next = -$signed({1'b0, cfg.correction_limit});
		end else begin
			corr_next = u_q[12:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q  <= action;
			elapsed_q <= elapsed_us;
			idx_q     <= motor_index;
			center_q  <= center_tick;
			pos_q     <= present_position;
			pvalid_q  <= position_valid;
		end
		if (cmd.mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		if (cmd.rom_rd) begin
			rom_q <= SINE_ROM[rom_addr];
		end
		if (cmd.ref_rnd) begin
			off_q <= ref_rnd_sum[26:15];
		end
		if (cmd.ref_en) begin
			ref_q <= clamp_tick(ref_raw, cfg.lowest_tick, cfg.highest_tick);
		end
		if (cmd.diff_en) begin
			diff_q <= $signed({21'd0, ref_q}) - $signed({pos_q[31], pos_q});
		end
		if (cmd.corr_rnd) begin
			u_q <= corr_rnd_sum[45:8];
		end
		if (cmd.lim_en) begin
			corr_q <= corr_next;
		end
		if (cmd.cmd_en) begin
			cmdv_q <= clamp_tick(cmd_raw, cfg.lowest_tick, cfg.highest_tick);
		end
		if (cmd.load_out) begin
			reference_q <= ref_q;
			command_q   <= pvalid_q ? cmdv_q : center_q;
			send_q      <= pvalid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + prod_q[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	assign sts.is_time   = !action_q;
	assign sts.in_range  = ({4'd0, idx_q} < MOTOR_LIMIT);
	assign sts.pos_valid = pvalid_q;
	assign sts.out_free  = !result_valid_q || !result_stall;

	assign result_valid = result_valid_q;
	assign reference    = reference_q;
	assign command      = command_q;
	assign send         = send_q;

endmodule

[hw/rtl/sine_trajectory_p_servo.sv]
// Motor transaction, valid position: decode, phase multiply, ROM read, amplitude multiply,
// round, reference clamp, difference, error multiply, round, limit, command, write.
// Invalid position: up to the reference clamp, then write. Index beyond the motor count:
// decode only. Time: decode, multiply, accumulate, no result. One shared 33x17 multiplier.
// arst_n clears the sequencer, the result valid flag and the phase accumulator and loads
// the register reset values; the sine ROM is constant, so no clearing pass is needed.
`timescale 1ns / 1ps

module sine_trajectory_p_servo #(
	parameter int MOTOR_COUNT     = 32,
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic               clk,
	input  logic               arst_n,

	// configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,

	// item channel
	input  logic               item_valid,
	output logic               item_stall,
	input  logic               action,
	input  logic [15:0]        elapsed_us,
	input  logic [4:0]         motor_index,
	input  logic [11:0]        center_tick,
	input  logic signed [31:0] present_position,
	input  logic               position_valid,

	// result channel
	output logic               result_valid,
	input  logic               result_stall,
	output logic [11:0]        reference,
	output logic [11:0]        command,
	output logic               send
);
	import stps_pkg::*;

	logic [10:0] amplitude_q;
	logic [11:0] gain_q8_q;
	logic [11:0] correction_limit_q;
	logic [11:0] lowest_tick_q;
	logic [11:0] highest_tick_q;
	logic [29:0] phase_rate_q;
	logic [15:0] axis_phase_step_q;

	logic        cfg_wr;
	logic [2:0]  reg_idx;
	cfg_t        cfg;
	cmd_t        cmd;
	sts_t        sts;

	// Zero wait states: every access completes in its access cycle.
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[4:2];

	// Write registers only while the servo is idle: not enforced, and not shadowed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amplitude_q        <= AMPLITUDE_RST;
			gain_q8_q          <= GAIN_Q8_RST;
			correction_limit_q <= CORRECTION_LIMIT_RST;
			lowest_tick_q      <= LOWEST_TICK_RST;
			highest_tick_q     <= HIGHEST_TICK_RST;
			phase_rate_q       <= PHASE_RATE_RST;
			axis_phase_step_q  <= AXIS_PHASE_STEP_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_AMPLITUDE:        amplitude_q        <= pwdata[10:0];
				REG_GAIN_Q8:          gain_q8_q          <= pwdata[11:0];
				REG_CORRECTION_LIMIT: correction_limit_q <= pwdata[11:0];
				REG_LOWEST_TICK:      lowest_tick_q      <= pwdata[11:0];
				REG_HIGHEST_TICK:     highest_tick_q     <= pwdata[11:0];
				REG_PHASE_RATE:       phase_rate_q       <= pwdata[29:0];
				REG_AXIS_PHASE_STEP:  axis_phase_step_q  <= pwdata[15:0];
				default: ; // unmapped slot: drop the write
			endcase
		end
	end

	// Read back, zero-extended; the unmapped slot reads as zero.
	always_comb begin
		case (reg_idx)
			REG_AMPLITUDE:        prdata = {21'd0, amplitude_q};
			REG_GAIN_Q8:          prdata = {20'd0, gain_q8_q};
			REG_CORRECTION_LIMIT: prdata = {20'd0, correction_limit_q};
			REG_LOWEST_TICK:      prdata = {20'd0, lowest_tick_q};
			REG_HIGHEST_TICK:     prdata = {20'd0, highest_tick_q};
			REG_PHASE_RATE:       prdata = {2'd0, phase_rate_q};
			REG_AXIS_PHASE_STEP:  prdata = {16'd0, axis_phase_step_q};
			default:              prdata = 32'd0;
		endcase
	end

	assign cfg.amplitude        = amplitude_q;
	assign cfg.gain_q8          = gain_q8_q;
	assign cfg.correction_limit = correction_limit_q;
	assign cfg.lowest_tick      = lowest_tick_q;
	assign cfg.highest_tick     = highest_tick_q;
	assign cfg.phase_rate       = phase_rate_q;
	assign cfg.axis_phase_step  = axis_phase_step_q;

	// The sequencer takes one transaction at a time and walks it through the datapath;
	// the datapath owns the phase accumulator, the sine ROM and the result register, so a
	// finished result can wait there while the next transaction is accepted.
	stps_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	stps_dp #(
		.MOTOR_COUNT     (MOTOR_COUNT),
		.SINE_TABLE_BITS (SINE_TABLE_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg),
		.cmd              (cmd),
		.sts              (sts),
		.action           (action),
		.elapsed_us       (elapsed_us),
		.motor_index      (motor_index),
		.center_tick      (center_tick),
		.present_position (present_position),
		.position_valid   (position_valid),
		.result_stall     (result_stall),
		.result_valid     (result_valid),
		.reference        (reference),
		.command          (command),
		.send             (send)
	);

`ifndef SYNTH
	// Never overwrite a result that is still waiting to be taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!result_valid || !result_stall))
		else $error("result register loaded while holding a stalled result");

	// After a transaction is taken the sequencer is busy on the next cycle.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> item_stall)
		else $error("second transaction accepted while the first is in flight");

	// The reference always lies inside an ordered tick window.
	a_ref_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (lowest_tick_q <= highest_tick_q)) |->
		((reference >= lowest_tick_q) && (reference <= highest_tick_q)))
		else $error("reference outside tick window");

	// A command that is sent always lies inside an ordered tick window.
	a_cmd_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && send && (lowest_tick_q <= highest_tick_q)) |->
		((command >= lowest_tick_q) && (command <= highest_tick_q)))
		else $error("sent command outside tick window");
`endif

endmodule

[sim/sine_trajectory_p_servo_tb.sv]
`timescale 1ns / 1ps

module sine_trajectory_p_servo_tb;
	import stps_pkg::*;

	// Block geometry as instantiated below
	localparam int MOTOR_COUNT = 32;
	localparam int SINE_BITS   = 10;
	localparam int SINE_SIZE   = 1 << SINE_BITS;

	// Fixed-point constants for the sine table (Q30)
	localparam longint unsigned SINE_PI_Q30  = 64'd3373259426;
	localparam longint unsigned SINE_ONE_Q30 = 64'd1073741824;

	// Action codes of an input transaction
	localparam logic ACT_TIME  = 1'b0;
	localparam logic ACT_MOTOR = 1'b1;

	// Random part: phases, each with its own register setting
	localparam int NUM_PHASES      = 6;
	localparam int ITEMS_PER_PHASE = 188;
	localparam int QUIET_PHASE     = 2;
	localparam int PRESSURE_PHASE  = 4;
	localparam int HOLD_CYCLES     = 400;

	typedef struct {
		logic               action;
		logic [15:0]        elapsed_us;
		logic [4:0]         motor_index;
		logic [11:0]        center_tick;
		logic signed [31:0] present_position;
		logic               position_valid;
	} servo_item_t;

	typedef struct {
		logic [11:0] reference;
		logic [11:0] command;
		logic        send;
	} servo_out_t;

	class servo_scoreboard;
		logic [10:0] amplitude;
		logic [11:0] gain_q8;
		logic [11:0] corr_limit;
		logic [11:0] lowest_tick;
		logic [11:0] highest_tick;
		logic [29:0] phase_rate;
		logic [15:0] axis_step;
		logic [31:0] phase_acc;
		logic signed [15:0] sine_rom [SINE_SIZE];
		servo_out_t expected_commands [$];
		int errors;

		function new();
			int unsigned quarter;
			logic signed [15:0] v;
			quarter = SINE_SIZE / 4;
			for (int k = 0; k < SINE_SIZE; k++) begin
				if (((k / quarter) & 1) != 0) begin
					v = $signed(quarter_wave(quarter - (k % quarter)));
				end else begin
					v = $signed(quarter_wave(k % quarter));
				end
				sine_rom[k] = (((k / quarter) & 2) != 0) ? -v : v;
			end
			amplitude    = AMPLITUDE_RST;
			gain_q8      = GAIN_Q8_RST;
			corr_limit   = CORRECTION_LIMIT_RST;
			lowest_tick  = LOWEST_TICK_RST;
			highest_tick = HIGHEST_TICK_RST;
			phase_rate   = PHASE_RATE_RST;
			axis_step    = AXIS_PHASE_STEP_RST;
			phase_acc    = '0;
			errors       = 0;
		endfunction

		// sine of r / SINE_SIZE turns for the first quadrant, Q15
		function logic [15:0] quarter_wave(int unsigned r);
			longint unsigned x;
			longint unsigned x2;
			longint unsigned t;
			longint unsigned d;
			longint unsigned s;
			longint unsigned q;
			longint unsigned divisor [5];
			divisor = '{110, 72, 42, 20, 6};
			x  = (SINE_PI_Q30 * r) >> (SINE_BITS - 1);
			x2 = (x * x) >> 30;
			t  = SINE_ONE_Q30;
			for (int i = 0; i < 5; i++) begin
				d = ((x2 * t) >> 30) / divisor[i];
				t = (d >= SINE_ONE_Q30) ? 64'd0 : SINE_ONE_Q30 - d;
			end
			s = (x * t) >> 30;
			q = (s + 64'd16384) >> 15;
			if (q > 64'd32767) begin
				q = 64'd32767;
			end
			return q[15:0];
		endfunction

		function longint round_half_away(longint p, int sh);
			longint m;
			m = (p < 0) ? -p : p;
			m = (m + (longint'(1) << (sh - 1))) >> sh;
			return (p < 0) ? -m : m;
		endfunction

		// an inverted window sends everything not below the low edge to the high edge
		function longint window(longint v);
			longint lo;
			longint hi;
			lo = longint'(lowest_tick);
			hi = longint'(highest_tick);
			if (v < lo) begin
				return lo;
			end
			if (v > hi) begin
				return hi;
			end
			return v;
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] data);
			case (idx)
				REG_AMPLITUDE:        amplitude    = data[10:0];
				REG_GAIN_Q8:          gain_q8      = data[11:0];
				REG_CORRECTION_LIMIT: corr_limit   = data[11:0];
				REG_LOWEST_TICK:      lowest_tick  = data[11:0];
				REG_HIGHEST_TICK:     highest_tick = data[11:0];
				REG_PHASE_RATE:       phase_rate   = data[29:0];
				REG_AXIS_PHASE_STEP:  axis_step    = data[15:0];
				default: ;
			endcase
		endfunction

		// advance the phase or predict the command of one motor
		function void take_item(servo_item_t it);
			logic [31:0] phase;
			int unsigned offs;
			longint refv;
			longint pos;
			longint corr;
			longint lim;
			longint cmd;
			servo_out_t want;
			if (it.action == ACT_TIME) begin
				phase_acc = phase_acc + 32'(longint'(it.elapsed_us) * longint'(phase_rate));
				return;
			end
			if (it.motor_index >= MOTOR_COUNT) begin
				return;
			end
			offs  = 32'(it.motor_index) * 32'(axis_step);
			phase = phase_acc + {offs[15:0], 16'h0000};
			refv  = longint'(it.center_tick) + round_half_away(
				longint'(amplitude) * longint'(sine_rom[phase[31:32-SINE_BITS]]), 15);
			refv  = window(refv);
			want.reference = refv[11:0];
			if (!it.position_valid) begin
				want.command = it.center_tick;
				want.send    = 1'b0;
			end else begin
				pos  = longint'(it.present_position);
				corr = round_half_away(longint'(gain_q8) * (refv - pos), 8);
				lim  = longint'(corr_limit);
				if (corr > lim) begin
					corr = lim;
				end
				if (corr < -lim) begin
					corr = -lim;
				end
				cmd = window(refv + corr);
				want.command = cmd[11:0];
				want.send    = 1'b1;
			end
			expected_commands.insert(expected_commands.size(), want);
		endfunction

		function void check_result(servo_out_t got);
			servo_out_t want;
			if (expected_commands.size() == 0) begin
				errors++;
				if (errors <= 10) begin
					$display("unexpected result: reference %0d command %0d send %0b",
						got.reference, got.command, got.send);
				end
				return;
			end
			want = expected_commands.pop_front();
			if (got.reference !== want.reference || got.command !== want.command ||
					got.send !== want.send) begin
				errors++;
				if (errors <= 10) begin
					$display("mismatch (exp/act): reference %0d/%0d command %0d/%0d send %0b/%0b",
						want.reference, got.reference, want.command, got.command,
						want.send, got.send);
				end
			end
		endfunction

		function int pending();
			return expected_commands.size();
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [4:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               item_valid;
	logic               item_stall;
	logic               action;
	logic [15:0]        elapsed_us;
	logic [4:0]         motor_index;
	logic [11:0]        center_tick;
	logic signed [31:0] present_position;
	logic               position_valid;
	logic               result_valid;
	logic               result_stall;
	logic [11:0]        reference;
	logic [11:0]        command;
	logic               send;

	// idling controls for the sender and the receiver; quiet is shared by both
	bit quiet    = 1'b0;
	bit rush     = 1'b0;
	bit hold_req = 1'b0;

	servo_scoreboard sb = new();

	sine_trajectory_p_servo #(
		.MOTOR_COUNT     (MOTOR_COUNT),
		.SINE_TABLE_BITS (SINE_BITS)
	) dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.item_valid       (item_valid),
		.item_stall       (item_stall),
		.action           (action),
		.elapsed_us       (elapsed_us),
		.motor_index      (motor_index),
		.center_tick      (center_tick),
		.present_position (present_position),
		.position_valid   (position_valid),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.reference        (reference),
		.command          (command),
		.send             (send)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Gap before the next transaction: mostly none or short, now and then long
	function automatic int idle_gap(bit off);
		int unsigned r;
		if (off) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	// Pick zero, the top value, or anything in between
	function automatic logic [31:0] pick_extreme(int unsigned top);
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			return 32'd0;
		end
		if (r == 1) begin
			return top;
		end
		return $urandom_range(0, top);
	endfunction

	// Write one register: setup cycle, then access cycle until pready.
	// Call right after a rising edge; returns right after one.
	task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(idx, data);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_config(logic [10:0] amp, logic [11:0] gain, logic [11:0] lim,
			logic [11:0] lo, logic [11:0] hi, logic [29:0] rate, logic [15:0] step);
		cfg_write(REG_AMPLITUDE, 32'(amp));
		cfg_write(REG_GAIN_Q8, 32'(gain));
		cfg_write(REG_CORRECTION_LIMIT, 32'(lim));
		cfg_write(REG_LOWEST_TICK, 32'(lo));
		cfg_write(REG_HIGHEST_TICK, 32'(hi));
		cfg_write(REG_PHASE_RATE, 32'(rate));
		cfg_write(REG_AXIS_PHASE_STEP, 32'(step));
	endtask

	// Offer one transaction and hold it until accepted. Sample stall at the
	// falling edge, so the value seen is the one the block acts on at the
	// next rising edge. Drop valid only when a gap follows.
	task automatic drive_item(servo_item_t it);
		int gap;
		bit taken;
		item_valid       <= 1'b1;
		action           <= it.action;
		elapsed_us       <= it.elapsed_us;
		motor_index      <= it.motor_index;
		center_tick      <= it.center_tick;
		present_position <= it.present_position;
		position_valid   <= it.position_valid;
		do begin
			@(negedge clk);
			taken = !item_stall;
			@(posedge clk);
		end while (!taken);
		sb.take_item(it);
		gap = idle_gap(quiet || rush);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic put_time(logic [15:0] us);
		servo_item_t it;
		it.action           = ACT_TIME;
		it.elapsed_us       = us;
		it.motor_index      = 5'($urandom);
		it.center_tick      = 12'($urandom);
		it.present_position = $urandom;
		it.position_valid   = 1'($urandom);
		drive_item(it);
	endtask

	task automatic put_motor(logic [4:0] idx, logic [11:0] center,
			logic signed [31:0] pos, logic ok);
		servo_item_t it;
		it.action           = ACT_MOTOR;
		it.elapsed_us       = 16'($urandom);
		it.motor_index      = idx;
		it.center_tick      = center;
		it.present_position = pos;
		it.position_valid   = ok;
		drive_item(it);
	endtask

	// Drain the block before touching registers: drop valid, wait for every
	// predicted result, then give a trailing time transaction room to finish.
	task automatic settle();
		if (item_valid) begin
			item_valid <= 1'b0;
		end
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Random register setting; the tick window is usually ordered, sometimes inverted
	task automatic random_config();
		logic [11:0] lo;
		logic [11:0] hi;
		logic [11:0] tmp;
		logic [29:0] rate;
		lo = 12'(pick_extreme(4095));
		hi = 12'(pick_extreme(4095));
		if ($urandom_range(0, 9) < 8 && lo > hi) begin
			tmp = lo;
			lo  = hi;
			hi  = tmp;
		end
		case ($urandom_range(0, 3))
			0: rate = '1;
			1: rate = 30'($urandom_range(0, 65535));
			default: rate = 30'($urandom);
		endcase
		load_config(11'(pick_extreme(2047)), 12'(pick_extreme(4095)),
			12'(pick_extreme(4095)), lo, hi, rate, 16'($urandom));
	endtask

	// Result side: check each transaction at the falling edge before the
	// rising edge that completes it; stall is ours and already settled.
	always @(negedge clk) begin
		servo_out_t got;
		if (arst_n === 1'b1 && result_valid === 1'b1 && result_stall === 1'b0) begin
			got.reference = reference;
			got.command   = command;
			got.send      = send;
			sb.check_result(got);
		end
	end

	// Receiver stall pattern. A hold request from the stimulus freezes the
	// output so the block backs up into its input.
	initial begin
		int n;
		int held;
		result_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				result_stall <= 1'b1;
				for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
				result_stall <= 1'b0;
			end else begin
				n = idle_gap(quiet);
				if (n > 0) begin
					result_stall <= 1'b1;
					repeat (n) @(posedge clk);
				end
				result_stall <= 1'b0;
			end
		end
	end

	// Stimulus
	initial begin
		servo_item_t it;
		int phase;
		int n;
		int span;
		int off;
		int unsigned r;

		// hold every input at a known value through reset
		arst_n           <= 1'b0;
		psel             <= 1'b0;
		penable          <= 1'b0;
		pwrite           <= 1'b0;
		paddr            <= '0;
		pwdata           <= '0;
		item_valid       <= 1'b0;
		action           <= ACT_TIME;
		elapsed_us       <= '0;
		motor_index      <= '0;
		center_tick      <= '0;
		present_position <= '0;
		position_valid   <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset setting: zero phase, large errors both ways, invalid position,
		// longest and empty time steps
		put_motor(5'd0, 12'd2048, 32'sd2048, 1'b1);
		put_motor(5'd31, 12'd4095, 32'h8000_0000, 1'b1);
		put_motor(5'd1, 12'd0, 32'h7FFF_FFFF, 1'b1);
		put_motor(5'd7, 12'd4095, 32'sd0, 1'b0);
		put_time(16'hFFFF);
		put_motor(5'd16, 12'd2000, 32'sd1990, 1'b1);
		put_time(16'h0000);
		put_motor(5'd2, 12'd1234, 32'sd1300, 1'b0);

		// Top values everywhere but the low tick edge; the accumulator wraps on the long steps
		settle();
		load_config(11'd2047, 12'd4095, 12'd4095, 12'd0, 12'd4095, '1, 16'hFFFF);
		put_motor(5'd0, 12'd0, 32'sd0, 1'b1);
		put_time(16'hFFFF);
		put_time(16'hFFFF);
		put_motor(5'd31, 12'd4095, 32'sd100, 1'b1);
		put_motor(5'd8, 12'd2048, 32'sd5000, 1'b1);
		put_time(16'd4096);
		put_motor(5'd3, 12'd2048, 32'sd2048, 1'b1);

		// Inverted window, unity gain, quarter-turn offset per motor
		settle();
		load_config(11'd1500, 12'd256, 12'd100, 12'd3000, 12'd1000, 30'h0040_0000, 16'h4000);
		put_motor(5'd0, 12'd500, 32'sd500, 1'b1);
		put_motor(5'd1, 12'd2000, 32'sd2100, 1'b1);
		put_motor(5'd2, 12'd3500, 32'sd3000, 1'b1);
		put_time(16'd1);
		put_motor(5'd3, 12'd4095, -32'sd7, 1'b1);
		put_motor(5'd4, 12'd0, 32'sd0, 1'b0);

		// All registers zero: the reference pins to zero, an invalid
		// position still returns its center unclamped
		settle();
		load_config('0, '0, '0, '0, '0, '0, '0);
		put_motor(5'd9, 12'd4095, 32'sd4000, 1'b1);
		put_time(16'hFFFF);
		put_motor(5'd10, 12'd123, 32'sd0, 1'b0);

		// Random phases, one register setting each. One phase runs without
		// idling; another blocks the result side while the sender keeps going.
		for (phase = 0; phase < NUM_PHASES; phase++) begin
			settle();
			random_config();
			quiet = (phase == QUIET_PHASE);
			if (phase == PRESSURE_PHASE) begin
				hold_req = 1'b1;
			end
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				rush = (phase == PRESSURE_PHASE) && (n < 80);
				it.action      = ($urandom_range(0, 99) < 30) ? ACT_TIME : ACT_MOTOR;
				r = $urandom_range(0, 9);
				it.elapsed_us  = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom);
				it.motor_index = 5'($urandom);
				it.center_tick = 12'(pick_extreme(4095));
				// keep most positions near the center so corrections stay
				// inside the limit; the rest roam the full 32-bit range
				r = $urandom_range(0, 99);
				if (r < 85) begin
					span = 1 << $urandom_range(1, 12);
					off  = int'($urandom_range(0, 2 * span)) - span;
					it.present_position = 32'(it.center_tick) + 32'(off);
				end else begin
					it.present_position = $urandom;
				end
				it.position_valid = ($urandom_range(0, 99) < 85);
				drive_item(it);
			end
			rush = 1'b0;
		end

		// Drain, then leave room for any stray result
		settle();
		quiet = 1'b1;
		repeat (30) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("sine_trajectory_p_servo_tb: clean");
		end else begin
			$display("sine_trajectory_p_servo_tb: errors");
		end
		$finish;
	end

	// Watchdog: several times the slowest legal run
	initial begin
		#3_000_000;
		$display("sine_trajectory_p_servo_tb: errors");
		$finish;
	end

endmodule
